// File: rtl/oets_pkg.sv
// ----------------------------------------------------------------------------
// oets_pkg
// types and cell opcodes shared by the transposition sorter
// ----------------------------------------------------------------------------
package oets_pkg;

  localparam int unsigned DATA_W = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } oets_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } oets_out_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN,
    OP_SORT
  } oets_op_t;

  typedef struct packed {
    oets_op_t op;
    logic     phase_odd;
  } oets_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } oets_state_t;

endpackage

// File: rtl/odd_even_transposition_sorter_top.sv
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter_top: loads one value per cycle while in the
// load state, then runs n transposition phases across the cell row, then
// gives one result per cycle while the output is not stalled. synchronous
// reset empties the row and clears count and overflow
// ----------------------------------------------------------------------------
module odd_even_transposition_sorter_top
  import oets_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  oets_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output oets_out_t out_data
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  oets_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] phase_cnt_r, phase_cnt_nxt;
  logic          phase_r, phase_nxt;
  logic          dropped_r, dropped_nxt;
  logic          out_valid_r;
  oets_out_t     out_data_r;

  logic          in_fire;
  logic          full;
  logic          emit_go;
  oets_ctrl_t    ctrl;

  logic signed [DATA_W-1:0] cell_val [MAX_ITEMS];
  logic                     cell_vld [MAX_ITEMS];

  assign in_fire = in_valid && in_ready;
  assign full    = (count_r == CW'(MAX_ITEMS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_data.is_last) begin
          state_nxt = ST_SORT;
        end
      end
      ST_SORT: begin
        if (phase_cnt_r == CW'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go && (count_r == CW'(1))) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs of the control
  always_comb begin
    in_ready       = 1'b0;
    emit_go        = 1'b0;
    ctrl.op        = OP_HOLD;
    ctrl.phase_odd = phase_r;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_fire && !full) begin
          ctrl.op = OP_SHIFT_UP;
        end
      end
      ST_SORT: begin
        ctrl.op = OP_SORT;
      end
      ST_EMIT: begin
        emit_go = !out_valid_r || out_ready;
        if (emit_go) begin
          ctrl.op = OP_SHIFT_DOWN;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    phase_cnt_nxt = phase_cnt_r;
    phase_nxt     = phase_r;
    dropped_nxt   = dropped_r;
    if (in_fire) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
      if (in_data.is_last) begin
        phase_cnt_nxt = full ? count_r : count_r + CW'(1);
        phase_nxt     = 1'b0;
      end
    end
    if (state_r == ST_SORT) begin
      phase_cnt_nxt = phase_cnt_r - CW'(1);
      phase_nxt     = !phase_r;
    end
    if (emit_go) begin
      count_nxt = count_r - CW'(1);
      if (count_r == CW'(1)) begin
        dropped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      phase_cnt_r <= '0;
      phase_r     <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      phase_cnt_r <= phase_cnt_nxt;
      phase_r     <= phase_nxt;
      dropped_r   <= dropped_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r.sorted_value <= cell_val[0];
      out_data_r.last_out     <= (count_r == CW'(1));
      out_data_r.overflow     <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // cell row: slot 0 takes new values and gives up results
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [DATA_W-1:0] lval, rval;
    logic                     lvld, rvld;

    if (i == 0) begin : g_head
      assign lval = in_data.value;
      assign lvld = (state_r == ST_LOAD);
    end else begin : g_mid
      assign lval = cell_val[i-1];
      assign lvld = cell_vld[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_body
      assign rval = cell_val[i+1];
      assign rvld = cell_vld[i+1];
    end

    oets_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .cell_odd    (1'(i % 2)),
      .left_value  (lval),
      .left_valid  (lvld),
      .right_value (rval),
      .right_valid (rvld),
      .value       (cell_val[i]),
      .valid       (cell_vld[i])
    );
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("element count beyond capacity");

  a_sort_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.is_last |=> (state_r == ST_SORT) && cell_vld[0])
    else $error("closing transfer did not start a sort of a nonempty set");

  a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
    cell_vld[1] |-> cell_vld[0])
    else $error("cell row has a gap at the head");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> cell_vld[0] && (count_r != '0))
    else $error("result taken from an empty row");
`endif

endmodule

// File: rtl/oets_cell.sv
// ----------------------------------------------------------------------------
// oets_cell
// one element slot: holds, shifts in, shifts out, or compares with its pair partner
// ----------------------------------------------------------------------------
module oets_cell
  import oets_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  oets_ctrl_t               ctrl,
  input  logic                     cell_odd,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic                     left_valid,
  input  logic signed [DATA_W-1:0] right_value,
  input  logic                     right_valid,
  output logic signed [DATA_W-1:0] value,
  output logic                     valid
);

  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic                     valid_r, valid_nxt;
  logic                     is_lower;

  assign is_lower = (cell_odd == ctrl.phase_odd);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    case (ctrl.op)
      OP_SHIFT_UP: begin
        value_nxt = left_value;
        valid_nxt = left_valid;
      end
      OP_SHIFT_DOWN: begin
        value_nxt = right_value;
        valid_nxt = right_valid;
      end
      OP_SORT: begin
        // lower slot keeps the min, upper slot keeps the max
        if (is_lower) begin
          if (valid_r && right_valid && (value_r > right_value)) begin
            value_nxt = right_value;
          end
        end else begin
          if (valid_r && left_valid && (left_value > value_r)) begin
            value_nxt = left_value;
          end
        end
      end
      default: begin
        value_nxt = value_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// File: tb/tb_odd_even_transposition_sorter_top.sv
// ----------------------------------------------------------------------------
// tb_odd_even_transposition_sorter_top
// checks the sorter against a software sort of each closed set: directed sets
// with extreme, equal and presorted values, sets at and beyond capacity, a
// long output hold that backs up the input, then random sets under random
// idling on both channels; each result is compared field by field in order
// ----------------------------------------------------------------------------
module tb_odd_even_transposition_sorter_top;
  import oets_pkg::*;

  localparam int unsigned MAX_ITEMS   = 64;
  localparam int unsigned ITEM_TARGET = 500;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT  = MAX_ITEMS + 40;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  oets_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  oets_out_t out_data;

  logic signed [DATA_W-1:0] open_set[$];
  logic                     set_dropped = 1'b0;
  oets_out_t                pending_sorted[$];

  int unsigned fail_count    = 0;
  int unsigned sent_items    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned rx_hold_left  = 0;
  int unsigned rx_stall_left = 0;
  logic        tx_idle_on    = 1'b1;
  logic        rx_idle_on    = 1'b1;

  odd_even_transposition_sorter_top #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(DATA_W-1){1'b1}}};
      1:       return {1'b1, {(DATA_W-1){1'b0}}};
      2:       return $signed(DATA_W'($urandom_range(0, 8))) - 4;
      default: return $signed(DATA_W'($urandom()));
    endcase
  endfunction

  function automatic void report_failure(string what, oets_out_t want, oets_out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected value %0d last %0b ovf %0b, got value %0d last %0b ovf %0b",
               what, want.sorted_value, want.last_out, want.overflow,
               got.sorted_value, got.last_out, got.overflow);
  endfunction

  // odd-even transposition over the closed set, then queue one result per element
  function automatic void sort_closed_set();
    logic signed [DATA_W-1:0] a[$];
    logic signed [DATA_W-1:0] t;
    logic                     swapped;
    oets_out_t                r;
    a = open_set;
    do begin
      swapped = 1'b0;
      for (int p = 0; p < 2; p++)
        for (int i = p; i + 1 < a.size(); i += 2)
          if (a[i] > a[i+1]) begin
            t      = a[i];
            a[i]   = a[i+1];
            a[i+1] = t;
            swapped = 1'b1;
          end
    end while (swapped);
    for (int k = 0; k < a.size(); k++) begin
      r.sorted_value = a[k];
      r.last_out     = (k == a.size() - 1);
      r.overflow     = set_dropped;
      pending_sorted.push_back(r);
    end
  endfunction

  function automatic void record_transfer(oets_in_t t);
    if (open_set.size() < MAX_ITEMS) open_set.push_back(t.value);
    else set_dropped = 1'b1;
    if (t.is_last) begin
      sort_closed_set();
      open_set.delete();
      set_dropped = 1'b0;
    end
  endfunction

  function automatic void check_result(oets_out_t got);
    oets_out_t want;
    if (pending_sorted.size() == 0) begin
      report_failure("unexpected result", '0, got);
      return;
    end
    want = pending_sorted.pop_front();
    if (got.sorted_value !== want.sorted_value || got.last_out !== want.last_out ||
        got.overflow !== want.overflow)
      report_failure("field", want, got);
  endfunction

  // transfer monitor, result check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        record_transfer(in_data);
        sent_items++;
      end
      if (out_valid && out_ready) check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side ready with random stalls and an optional long hold
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_on) rx_stall_left = idle_gap();
    end
  end

  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic last);
    oets_in_t    item;
    int unsigned gap;
    item.value   = v;
    item.is_last = last;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = tx_idle_on ? idle_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_list(input logic signed [DATA_W-1:0] vals[$]);
    for (int i = 0; i < vals.size(); i++) send_item(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_set(input int unsigned len);
    for (int i = 0; i < len; i++) send_item(rand_value(), i == len - 1);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_sets();
    logic signed [DATA_W-1:0] vals[$];
    vals = '{32'sh7fffffff};
    send_list(vals);
    vals = '{32'sh80000000};
    send_list(vals);
    vals = '{32'sd5, -32'sd5};
    send_list(vals);
    vals = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd1};
    send_list(vals);
    vals = '{32'sd3, 32'sd3, -32'sd2, 32'sd3};
    send_list(vals);
    vals = '{-32'sd100, -32'sd1, 32'sd0, 32'sd100};
    send_list(vals);
    vals = '{32'sd60, 32'sd50, 32'sd40, 32'sd30, 32'sd20, 32'sh80000000};
    send_list(vals);
  endtask

  task automatic test_capacity();
    tx_idle_on = 1'b0;
    send_random_set(MAX_ITEMS);
    send_random_set(MAX_ITEMS + 1);
    tx_idle_on = 1'b1;
    send_random_set(MAX_ITEMS + 3);
    send_random_set(2);
  endtask

  task automatic test_output_stall();
    tx_idle_on = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
    rx_hold_left = 300;
    send_random_set(8);
    send_random_set(12);
    send_random_set(3);
    // sender pause until the block has emptied
    wait_results_drained();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_sets();
    int unsigned r;
    int unsigned len;
    while (sent_items < ITEM_TARGET) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 92) len = $urandom_range(9, MAX_ITEMS);
      else len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
      send_random_set(len);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_sets();
    test_capacity();
    test_output_stall();
    test_random_sets();
    @(negedge clk);
    in_valid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_sorted.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
